[rtl/core/salc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  // geometry
  localparam int unsigned SETS       = 64;
  localparam int unsigned WAYS       = 8;
  localparam int unsigned LINE_SHIFT = 6;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned LINE_W  = ADDR_W - LINE_SHIFT;
  localparam int unsigned SET_W   = $clog2(SETS);
  localparam int unsigned TAG_W   = LINE_W - SET_W;
  localparam int unsigned WAY_W   = $clog2(WAYS);
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CNT_W   = 32;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic              writeback_valid;
    logic [LINE_W-1:0] writeback_line;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
  } out_t;

  // one way of the directory
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               valid;
    logic               dirty;
    logic [STAMP_W-1:0] stamp;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  // running result of the way scan
  typedef struct packed {
    logic               hit;
    logic [WAY_W-1:0]   hit_way;
    logic               inv;
    logic [WAY_W-1:0]   inv_way;
    logic [WAY_W-1:0]   lru_way;
    logic [STAMP_W-1:0] lru_stamp;
  } scan_t;

endpackage

`default_nettype wire

[rtl/core/salc_dir_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module salc_dir_ram (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [salc_pkg::SET_W-1:0] waddr_i,
  input  wire salc_pkg::row_t            wdata_i,
  input  wire logic                      re_i,
  input  wire logic [salc_pkg::SET_W-1:0] raddr_i,
  output salc_pkg::row_t                 rdata_o
);

  salc_pkg::row_t mem_q [salc_pkg::SETS];
  salc_pkg::row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/salc_way_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module salc_way_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic                      first_i,
  input  wire logic [salc_pkg::WAY_W-1:0] way_idx_i,
  input  wire salc_pkg::way_t            entry_i,
  input  wire logic [salc_pkg::TAG_W-1:0] tag_i,
  output salc_pkg::scan_t                acc_o
);

  salc_pkg::scan_t acc_q, acc_d;
  logic            match;

  always_comb begin
    match = entry_i.valid && (entry_i.tag == tag_i);
    acc_d = acc_q;
    if (first_i) begin
      acc_d.hit       = match;
      acc_d.hit_way   = way_idx_i;
      acc_d.inv       = !entry_i.valid;
      acc_d.inv_way   = way_idx_i;
      acc_d.lru_way   = way_idx_i;
      acc_d.lru_stamp = entry_i.stamp;
    end else begin
      if (!acc_q.hit && match) begin
        acc_d.hit     = 1'b1;
        acc_d.hit_way = way_idx_i;
      end
      if (!acc_q.inv && !entry_i.valid) begin
        acc_d.inv     = 1'b1;
        acc_d.inv_way = way_idx_i;
      end
      // strictly older only, so ties keep the lower way
      if (entry_i.stamp < acc_q.lru_stamp) begin
        acc_d.lru_way   = way_idx_i;
        acc_d.lru_stamp = entry_i.stamp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (step_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

[rtl/core/set_assoc_lru_writeback_cache.sv]
// a word taken in idle goes through the read, scan and done states, and its result is then
//   registered on out_valid_o; done waits while an unread result still holds the output register
// no new word is taken until that result is registered, as the scan walks
//   the ways of one set through a single tag and stamp comparator, one way a cycle
// reset: asynchronous, active low; the directory is then cleared one set a cycle,
//   every set in turn, with in_ready_o low until the pass is over
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_writeback_cache (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire salc_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output salc_pkg::out_t     out_data_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                          state_q;
  logic [salc_pkg::SET_W-1:0]      clr_q;
  logic [salc_pkg::WAY_W-1:0]      way_q;
  salc_pkg::cmd_e                  cmd_q;
  logic [salc_pkg::SET_W-1:0]      set_q;
  logic [salc_pkg::TAG_W-1:0]      tag_q;
  logic [salc_pkg::STAMP_W-1:0]    stamp_q;
  logic [salc_pkg::CNT_W-1:0]      hits_q, hits_d;
  logic [salc_pkg::CNT_W-1:0]      misses_q, misses_d;
  logic                            out_valid_q;
  salc_pkg::out_t                  out_q, out_d;

  // directory port and scan unit hookup
  logic                            ram_we;
  logic [salc_pkg::SET_W-1:0]      ram_waddr;
  salc_pkg::row_t                  ram_wdata;
  logic                            ram_re;
  salc_pkg::row_t                  rdata;
  salc_pkg::scan_t                 acc;
  logic                            scan_step;

  // update of the set at the end of the scan
  logic                            hit_use;
  logic                            alloc;
  logic                            is_wr;
  logic                            wb;
  logic [salc_pkg::WAY_W-1:0]      vic_way;
  salc_pkg::way_t                  vic;
  salc_pkg::row_t                  new_row;
  logic                            done_fire;

  salc_dir_ram u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (set_q),
    .rdata_o (rdata)
  );

  assign scan_step = (state_q == ST_SCAN);

  salc_way_unit u_way_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (scan_step),
    .first_i   (way_q == '0),
    .way_idx_i (way_q),
    .entry_i   (rdata[way_q]),
    .tag_i     (tag_q),
    .acc_o     (acc)
  );

  always_comb begin
    is_wr   = (cmd_q == salc_pkg::CMD_WRITE);
    // an unused command never hits and never allocates
    hit_use = acc.hit && (cmd_q != salc_pkg::CMD_NONE);
    alloc   = !acc.hit && (cmd_q == salc_pkg::CMD_FILL || is_wr);

    // first invalid way, else the oldest stamp
    vic_way = acc.inv ? acc.inv_way : acc.lru_way;
    vic     = rdata[vic_way];
    wb      = alloc && vic.valid && vic.dirty;

    new_row = rdata;
    if (hit_use) begin
      new_row[acc.hit_way].stamp = stamp_q;
      if (is_wr) begin
        new_row[acc.hit_way].dirty = 1'b1;
      end
    end
    if (alloc) begin
      new_row[vic_way].tag   = tag_q;
      new_row[vic_way].valid = 1'b1;
      new_row[vic_way].dirty = is_wr;
      new_row[vic_way].stamp = stamp_q;
    end

    // saturating write hit and miss counters
    hits_d = hits_q;
    if (hit_use && is_wr && (hits_q != '1)) begin
      hits_d = hits_q + salc_pkg::CNT_W'(1);
    end
    misses_d = misses_q;
    if (alloc && is_wr && (misses_q != '1)) begin
      misses_d = misses_q + salc_pkg::CNT_W'(1);
    end

    out_d.hit             = hit_use;
    out_d.writeback_valid = wb;
    out_d.writeback_line  = wb ? {vic.tag, set_q} : '0;
    out_d.hit_count       = hits_d;
    out_d.miss_count      = misses_d;

    // finish only once the output register is free or being drained
    done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

    ram_re    = (state_q == ST_READ);
    ram_we    = (state_q == ST_CLEAR) || (done_fire && (hit_use || alloc));
    ram_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;
    ram_wdata = (state_q == ST_CLEAR) ? '0 : new_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      way_q       <= '0;
      cmd_q       <= salc_pkg::CMD_NONE;
      set_q       <= '0;
      tag_q       <= '0;
      stamp_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // a drained result is replaced in the same cycle by a finishing one
      if (out_valid_q && out_ready_i && !done_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + salc_pkg::SET_W'(1);
          if (clr_q == salc_pkg::SET_W'(salc_pkg::SETS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q <= in_data_i.command;
            set_q <= in_data_i.address[salc_pkg::LINE_SHIFT +: salc_pkg::SET_W];
            tag_q <= in_data_i.address[salc_pkg::ADDR_W-1 -: salc_pkg::TAG_W];
            // the stamp only moves for a real command
            if (in_data_i.command != salc_pkg::CMD_NONE) begin
              stamp_q <= stamp_q + salc_pkg::STAMP_W'(1);
            end
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          way_q   <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          way_q <= way_q + salc_pkg::WAY_W'(1);
          if (way_q == salc_pkg::WAY_W'(salc_pkg::WAYS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_fire) begin
            hits_q      <= hits_d;
            misses_q    <= misses_d;
            out_q       <= out_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/core/salc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module salc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire salc_pkg::out_t out_data_o
);

  // one word in flight at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again straight after a word");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // an eviction only happens on a miss
  a_wb_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.writeback_valid))
    else $error("writeback reported on a hit");

  // no writeback, no line
  a_wb_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.writeback_valid |-> out_data_o.writeback_line == '0)
    else $error("writeback line set without a writeback");

endmodule

bind set_assoc_lru_writeback_cache salc_checker u_salc_checker (.*);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAG_POOL    = 12;

  // recognisable tag for the directed part, A and 5 nibbles in turn across all 52 bits
  localparam logic [salc_pkg::TAG_W-1:0] TAG_ALT = 52'hA_5A5A_5A5A_5A5A;
  localparam logic [salc_pkg::SET_W-1:0] SET_DIR = salc_pkg::SET_W'(5);

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  salc_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  salc_pkg::out_t out_data_o;

  set_assoc_lru_writeback_cache u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // shadow copy of the tag directory
  logic [salc_pkg::TAG_W-1:0]   dir_tag   [salc_pkg::SETS][salc_pkg::WAYS];
  logic                         dir_valid [salc_pkg::SETS][salc_pkg::WAYS];
  logic                         dir_dirty [salc_pkg::SETS][salc_pkg::WAYS];
  logic [salc_pkg::STAMP_W-1:0] dir_age   [salc_pkg::SETS][salc_pkg::WAYS];
  logic [salc_pkg::STAMP_W-1:0] age_now;
  logic [salc_pkg::CNT_W-1:0]   write_hits;
  logic [salc_pkg::CNT_W-1:0]   write_misses;

  // results still owed by the block, oldest first
  salc_pkg::out_t expected_q[$];

  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_count   = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold      = 1'b0;

  // address pools that keep random traffic on a few busy sets
  logic [salc_pkg::TAG_W-1:0] tag_pool [TAG_POOL];
  logic [salc_pkg::SET_W-1:0] busy_sets [4];

  function automatic logic [salc_pkg::ADDR_W-1:0] line_addr(
      logic [salc_pkg::TAG_W-1:0]      tag,
      logic [salc_pkg::SET_W-1:0]      set_idx,
      logic [salc_pkg::LINE_SHIFT-1:0] offset);
    return {tag, set_idx, offset};
  endfunction

  task automatic clear_directory();
    for (int s = 0; s < salc_pkg::SETS; s++) begin
      for (int w = 0; w < salc_pkg::WAYS; w++) begin
        dir_tag[s][w]   = '0;
        dir_valid[s][w] = 1'b0;
        dir_dirty[s][w] = 1'b0;
        dir_age[s][w]   = '0;
      end
    end
    age_now      = '0;
    write_hits   = '0;
    write_misses = '0;
  endtask

  // one access against the shadow directory; returns the word the block owes
  function automatic salc_pkg::out_t predict_access(salc_pkg::in_t w);
    logic [salc_pkg::LINE_W-1:0] line;
    logic [salc_pkg::SET_W-1:0]  set_idx;
    logic [salc_pkg::TAG_W-1:0]  tag;
    int                          hit_way;
    int                          victim;
    int                          i;
    salc_pkg::out_t              r;
    line    = w.address[salc_pkg::ADDR_W-1:salc_pkg::LINE_SHIFT];
    set_idx = line[salc_pkg::SET_W-1:0];
    tag     = line[salc_pkg::LINE_W-1:salc_pkg::SET_W];
    r       = '0;
    if (w.command != salc_pkg::CMD_NONE) begin
      age_now = age_now + salc_pkg::STAMP_W'(1);
      hit_way = -1;
      for (i = salc_pkg::WAYS - 1; i >= 0; i--) begin
        if (dir_valid[set_idx][i] && dir_tag[set_idx][i] == tag) hit_way = i;
      end
      if (hit_way >= 0) begin
        r.hit = 1'b1;
        dir_age[set_idx][hit_way] = age_now;
        if (w.command == salc_pkg::CMD_WRITE) begin
          dir_dirty[set_idx][hit_way] = 1'b1;
          if (write_hits != '1) write_hits = write_hits + salc_pkg::CNT_W'(1);
        end
      end else if (w.command != salc_pkg::CMD_LOOKUP) begin
        // first empty way, else the oldest stamp with the lowest way on a tie
        victim = -1;
        for (i = salc_pkg::WAYS - 1; i >= 0; i--) begin
          if (!dir_valid[set_idx][i]) victim = i;
        end
        if (victim < 0) begin
          victim = 0;
          for (i = 1; i < salc_pkg::WAYS; i++) begin
            if (dir_age[set_idx][i] < dir_age[set_idx][victim]) victim = i;
          end
        end
        if (dir_valid[set_idx][victim] && dir_dirty[set_idx][victim]) begin
          r.writeback_valid = 1'b1;
          r.writeback_line  = {dir_tag[set_idx][victim], set_idx};
        end
        dir_tag[set_idx][victim]   = tag;
        dir_valid[set_idx][victim] = 1'b1;
        dir_age[set_idx][victim]   = age_now;
        dir_dirty[set_idx][victim] = (w.command == salc_pkg::CMD_WRITE);
        if (w.command == salc_pkg::CMD_WRITE && write_misses != '1) begin
          write_misses = write_misses + salc_pkg::CNT_W'(1);
        end
      end
    end
    r.hit_count  = write_hits;
    r.miss_count = write_misses;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic check_result(salc_pkg::out_t got);
    salc_pkg::out_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected word", 64'(got), '0);
      return;
    end
    want = expected_q.pop_front();
    if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
    if (got.writeback_valid !== want.writeback_valid)
      report_mismatch("writeback_valid", 64'(got.writeback_valid), 64'(want.writeback_valid));
    if (got.writeback_line !== want.writeback_line)
      report_mismatch("writeback_line", 64'(got.writeback_line), 64'(want.writeback_line));
    if (got.hit_count !== want.hit_count)
      report_mismatch("hit_count", 64'(got.hit_count), 64'(want.hit_count));
    if (got.miss_count !== want.miss_count)
      report_mismatch("miss_count", 64'(got.miss_count), 64'(want.miss_count));
  endtask

  // sample both sides with the values held before the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // offers one word, with a random gap first, and holds it until taken;
  // valid is left high so a following word goes out without a bubble
  task automatic send_word(salc_pkg::in_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(predict_access(w));
  endtask

  task automatic send_access(salc_pkg::cmd_e command,
                             logic [salc_pkg::ADDR_W-1:0] address);
    salc_pkg::in_t w;
    w.command = command;
    w.address = address;
    send_word(w);
  endtask

  task automatic refresh_pools();
    for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = salc_pkg::TAG_W'({$urandom, $urandom});
    for (int i = 0; i < 4; i++) busy_sets[i] = salc_pkg::SET_W'($urandom);
  endtask

  // mostly busy sets and a pool of more tags than ways, so hits, refreshes
  // and evictions of dirty lines all come up; some fully random addresses
  function automatic salc_pkg::in_t random_word();
    salc_pkg::in_t w;
    int unsigned   pick;
    pick = $urandom_range(99);
    if (pick < 30)      w.command = salc_pkg::CMD_LOOKUP;
    else if (pick < 55) w.command = salc_pkg::CMD_FILL;
    else if (pick < 96) w.command = salc_pkg::CMD_WRITE;
    else                w.command = salc_pkg::CMD_NONE;
    pick = $urandom_range(99);
    if (pick < 70)
      w.address = line_addr(tag_pool[$urandom_range(TAG_POOL - 1)],
                            busy_sets[$urandom_range(3)],
                            salc_pkg::LINE_SHIFT'($urandom));
    else if (pick < 90)
      w.address = line_addr(tag_pool[$urandom_range(TAG_POOL - 1)],
                            salc_pkg::SET_W'($urandom),
                            salc_pkg::LINE_SHIFT'($urandom));
    else
      w.address = {$urandom, $urandom};
    return w;
  endfunction

  task automatic run_random_phase(int unsigned count, int unsigned tx_pct,
                                  int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct <= rx_pct;
    refresh_pools();
    repeat (count) send_word(random_word());
  endtask

  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    // empty directory, unused command, all-ones address
    send_access(salc_pkg::CMD_LOOKUP, '0);
    send_access(salc_pkg::CMD_NONE, '1);
    send_access(salc_pkg::CMD_LOOKUP, '1);
    send_access(salc_pkg::CMD_FILL, '1);
    send_access(salc_pkg::CMD_WRITE, '1);
    // write miss then hits on the same line with different offsets
    send_access(salc_pkg::CMD_WRITE, line_addr(TAG_ALT, SET_DIR, '0));
    send_access(salc_pkg::CMD_LOOKUP, line_addr(TAG_ALT, SET_DIR, '1));
    send_access(salc_pkg::CMD_WRITE,
                line_addr(TAG_ALT, SET_DIR, salc_pkg::LINE_SHIFT'(1)));
    // fill of a present dirty line keeps it dirty
    send_access(salc_pkg::CMD_FILL, line_addr(TAG_ALT, SET_DIR, '0));
    // fill the rest of the set, refresh one way, then force evictions
    for (int i = 1; i < salc_pkg::WAYS; i++)
      send_access(salc_pkg::CMD_FILL,
                  line_addr(TAG_ALT ^ salc_pkg::TAG_W'(i), SET_DIR, '0));
    send_access(salc_pkg::CMD_LOOKUP,
                line_addr(TAG_ALT ^ salc_pkg::TAG_W'(2), SET_DIR, '0));
    send_access(salc_pkg::CMD_FILL,
                line_addr(TAG_ALT ^ salc_pkg::TAG_W'(8), SET_DIR, '0));
    send_access(salc_pkg::CMD_WRITE,
                line_addr(TAG_ALT ^ salc_pkg::TAG_W'(9), SET_DIR, '0));
    for (int i = 10; i < 17; i++)
      send_access(salc_pkg::CMD_FILL,
                  line_addr(TAG_ALT ^ salc_pkg::TAG_W'(i), SET_DIR, '0));
  endtask

  task automatic test_random_no_idle();
    run_random_phase(500, 0, 0);
  endtask

  task automatic test_random_sender_gaps();
    run_random_phase(500, 45, 0);
  endtask

  task automatic test_random_receiver_stalls();
    run_random_phase(500, 0, 45);
  endtask

  task automatic test_random_both_idle();
    run_random_phase(500, 9, 9);
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_input_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    refresh_pools();
    fork
      begin
        rx_hold    <= 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(posedge clk_i);
          hold_count++;
        end
        rx_hold <= 1'b0;
      end
      begin
        repeat (40) send_word(random_word());
      end
    join
  endtask

  initial begin
    clear_directory();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_no_idle();
    test_input_backpressure();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();

    // drain, then wait on to catch stray words
    in_valid_i   <= 1'b0;
    rx_stall_pct <= 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * (salc_pkg::WAYS + 3)) @(posedge clk_i);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/salc_pkg.sv
rtl/core/salc_dir_ram.sv
rtl/core/salc_way_unit.sv
rtl/core/set_assoc_lru_writeback_cache.sv
rtl/core/salc_checker.sv
tb/tb.sv
